>>> design/atce_pkg.sv
// ----------------------------------------------------------------------------
// atce_pkg
// shared types, widths and character codes of the ansi text console engine
// ----------------------------------------------------------------------------
`default_nettype none

package atce_pkg;

    // default screen geometry and parameter count
    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 25;
    localparam int DEF_MAX_PARAMS  = 16;

    // widths of the word fields
    localparam int CHAR_W  = 8;
    localparam int RADDR_W = 11;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;
    localparam int OPOS_W  = 11;
    localparam int CELL_W  = 16;
    localparam int PARAM_W = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        ATTR_RESET = 8'h07;
    localparam logic [7:0]        ATTR_BOLD  = 8'h0f;
    localparam logic [7:0]        ATTR_REV   = 8'h70;

    // word kinds carried in tuser
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // byte codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_QUES  = 8'h3f;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UJ    = 8'h4a;
    localparam logic [7:0] CH_UK    = 8'h4b;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_LM    = 8'h6d;

    // sgr code bases
    localparam logic [7:0] SGR_FG_LO  = 8'd30;
    localparam logic [7:0] SGR_FG_HI  = 8'd37;
    localparam logic [7:0] SGR_BG_LO  = 8'd40;
    localparam logic [7:0] SGR_BG_HI  = 8'd47;
    localparam logic [7:0] SGR_BR_LO  = 8'd90;
    localparam logic [7:0] SGR_BR_HI  = 8'd97;
    localparam logic [PARAM_W-1:0] SGR_BOLD  = 16'd1;
    localparam logic [PARAM_W-1:0] SGR_ULINE = 16'd4;
    localparam logic [PARAM_W-1:0] SGR_REV   = 16'd7;
    localparam logic [PARAM_W-1:0] SGR_NOREV = 16'd27;

    // erase modes
    localparam logic [PARAM_W-1:0] ERASE_TO_END   = 16'd0;
    localparam logic [PARAM_W-1:0] ERASE_TO_START = 16'd1;
    localparam logic [PARAM_W-1:0] ERASE_ALL      = 16'd2;

    typedef enum logic [1:0] {
        PS_TEXT,
        PS_ESC,
        PS_CSI_START,
        PS_CSI_PARAM
    } t_parse;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_SCR_RD,
        SQ_SCR_WR,
        SQ_FILL,
        SQ_PUT,
        SQ_SGR
    } t_seq;

    typedef struct packed {
        logic               op;
        logic [CHAR_W-1:0]  char_code;
        logic [RADDR_W-1:0] read_addr;
    } t_item;

endpackage

`default_nettype wire

>>> design/atce_ram.sv
// ----------------------------------------------------------------------------
// atce_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module atce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/atce_front.sv
// ----------------------------------------------------------------------------
// atce_front
// accepts input words and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module atce_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire atce_pkg::t_item                 i_item,
    output logic                                 o_q_valid,
    output atce_pkg::t_item                      o_q_item,
    input  wire logic                            i_q_pop
);
    import atce_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push;

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> design/atce_back.sv
// ----------------------------------------------------------------------------
// atce_back
// escape parser, cursor state and screen sequencer with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module atce_back #(
    parameter int SCREEN_COLS = atce_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = atce_pkg::DEF_SCREEN_ROWS,
    parameter int MAX_PARAMS  = atce_pkg::DEF_MAX_PARAMS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire atce_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [atce_pkg::OCOL_W-1:0]        o_col,
    output logic [atce_pkg::OROW_W-1:0]        o_row,
    output logic [atce_pkg::OPOS_W-1:0]        o_pos,
    output logic [atce_pkg::CELL_W-1:0]        o_cell
);
    import atce_pkg::*;

    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(SCREEN_COLS + 1);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int PC_W   = $clog2(MAX_PARAMS);
    localparam int SCR_LAST = CELLS - SCREEN_COLS - 1;

    t_seq               r_state, n_state;
    t_parse             r_ps, n_ps;
    logic [PARAM_W-1:0] r_vals [MAX_PARAMS];
    logic [PARAM_W-1:0] n_vals [MAX_PARAMS];
    logic [PC_W-1:0]    r_cnt, n_cnt;
    logic [COL_W-1:0]   r_col, n_col, r_scol, n_scol;
    logic [ROW_W-1:0]   r_row, n_row, r_srow, n_srow;
    logic [POS_W-1:0]   r_pos, n_pos, r_idx, n_idx, r_end, n_end;
    logic [7:0]         r_attr, n_attr, r_pch, n_pch;
    logic               r_pend, n_pend, r_rd_ok, n_rd_ok;
    logic [PC_W-1:0]    r_sgr, n_sgr;
    logic               r_ov;
    logic [OCOL_W-1:0]  r_ocol;
    logic [OROW_W-1:0]  r_orow;
    logic [OPOS_W-1:0]  r_opos;
    logic [CELL_W-1:0]  r_ocell, n_ocell;
    logic               finish;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [CELL_W-1:0]  wdata, rdata;

    // working signals of the decode
    logic [PARAM_W-1:0] e_vals [MAX_PARAMS];
    logic [PC_W-1:0]    e_cnt;
    logic [PARAM_W-1:0] p0, p1, d0, d1;
    logic [16:0]        nmov;
    logic [19:0]        acc;
    logic               mv;
    logic signed [17:0] tc, tr;
    logic [7:0]         c, sp, sdiff;
    logic [PARAM_W-1:0] sfull;
    logic               take;
    logic [ROW_W:0]     row_inc;

    atce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign take    = i_q_valid && (!r_ov || i_ready) && (r_state == SQ_IDLE);
    assign o_q_pop = take;
    assign o_valid = r_ov;
    assign o_col   = r_ocol;
    assign o_row   = r_orow;
    assign o_pos   = r_opos;
    assign o_cell  = r_ocell;
    assign row_inc = {1'b0, r_row} + 1'b1;

    always_comb begin
        n_state = r_state;
        n_ps    = r_ps;
        n_vals  = r_vals;
        n_cnt   = r_cnt;
        n_col   = r_col;
        n_row   = r_row;
        n_pos   = r_pos;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_idx   = r_idx;
        n_end   = r_end;
        n_attr  = r_attr;
        n_pch   = r_pch;
        n_pend  = r_pend;
        n_rd_ok = r_rd_ok;
        n_sgr   = r_sgr;
        n_ocell = '0;
        finish  = 1'b0;
        we      = 1'b0;
        waddr   = AW'(r_pos);
        wdata   = BLANK_CELL;
        raddr   = '0;
        mv      = 1'b0;
        tc      = $signed(18'(r_col));
        tr      = $signed(18'(r_row));
        c       = i_q_item.char_code;
        e_vals  = r_vals;
        e_cnt   = r_cnt;
        if (r_ps == PS_CSI_START) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
                e_vals[i] = '0;
            end
            e_cnt = '0;
        end
        p0    = e_vals[0];
        p1    = e_vals[1];
        d0    = (p0 != '0) ? p0 - 1'b1 : '0;
        d1    = (p1 != '0) ? p1 - 1'b1 : '0;
        nmov  = (p0 != '0) ? 17'(p0) : 17'd1;
        acc   = {e_vals[e_cnt], 3'b000} + {3'b000, e_vals[e_cnt], 1'b0}
                + 20'(c - CH_0);
        sfull = r_vals[r_sgr];
        sp    = sfull[7:0];
        sdiff = '0;

        case (r_state)
            SQ_IDLE: begin
                if (take) begin
                    if (i_q_item.op == OP_READ) begin
                        n_rd_ok = (i_q_item.read_addr < RADDR_W'(CELLS));
                        raddr   = n_rd_ok ? AW'(i_q_item.read_addr) : '0;
                        n_state = SQ_READ;
                    end else begin
                        case (r_ps)
                            PS_TEXT: begin
                                finish = 1'b1;
                                if (c >= CH_SPACE && c <= CH_TILDE) begin
                                    wdata = {r_attr, c};
                                    if (r_col >= COL_W'(SCREEN_COLS)) begin
                                        if (row_inc < (ROW_W+1)'(SCREEN_ROWS)) begin
                                            we    = 1'b1;
                                            n_col = COL_W'(1);
                                            n_row = ROW_W'(row_inc);
                                            n_pos = r_pos + 1'b1;
                                        end else begin
                                            // wrap on the bottom row: scroll first
                                            finish  = 1'b0;
                                            n_col   = '0;
                                            n_pos   = r_pos - POS_W'(SCREEN_COLS);
                                            n_pend  = 1'b1;
                                            n_pch   = c;
                                            n_idx   = '0;
                                            n_state = SQ_SCR_RD;
                                        end
                                    end else begin
                                        we    = 1'b1;
                                        n_col = r_col + 1'b1;
                                        n_pos = r_pos + 1'b1;
                                    end
                                end else if (c == CH_ESC) begin
                                    n_ps = PS_ESC;
                                end else if (c == CH_LF) begin
                                    n_col = '0;
                                    if (row_inc < (ROW_W+1)'(SCREEN_ROWS)) begin
                                        n_row = ROW_W'(row_inc);
                                        n_pos = r_pos - POS_W'(r_col)
                                                + POS_W'(SCREEN_COLS);
                                    end else begin
                                        finish  = 1'b0;
                                        n_pos   = r_pos - POS_W'(r_col);
                                        n_pend  = 1'b0;
                                        n_idx   = '0;
                                        n_state = SQ_SCR_RD;
                                    end
                                end else if (c == CH_CR) begin
                                    n_col = '0;
                                    n_pos = r_pos - POS_W'(r_col);
                                end else if (c == CH_DEL || c == CH_BS) begin
                                    if (r_col != '0) begin
                                        n_col = r_col - 1'b1;
                                        n_pos = r_pos - 1'b1;
                                        we    = (c == CH_DEL);
                                        waddr = AW'(n_pos);
                                        wdata = BLANK_CELL;
                                    end
                                end
                            end
                            PS_ESC: begin
                                finish = 1'b1;
                                n_ps   = PS_TEXT;
                                if (c == CH_LBRK) begin
                                    n_ps = PS_CSI_START;
                                end else if (c == CH_UE) begin
                                    mv = 1'b1;
                                    tc = '0;
                                    tr = $signed(18'(row_inc));
                                end else if (c == CH_UD) begin
                                    if (row_inc < (ROW_W+1)'(SCREEN_ROWS)) begin
                                        n_row = ROW_W'(row_inc);
                                        n_pos = r_pos + POS_W'(SCREEN_COLS);
                                    end else begin
                                        finish  = 1'b0;
                                        n_pend  = 1'b0;
                                        n_idx   = '0;
                                        n_state = SQ_SCR_RD;
                                    end
                                end else if (c == CH_7) begin
                                    n_scol = r_col;
                                    n_srow = r_row;
                                end else if (c == CH_8) begin
                                    n_col = r_scol;
                                    n_row = r_srow;
                                    n_pos = POS_W'(POS_W'(r_srow) * POS_W'(SCREEN_COLS)
                                            + POS_W'(r_scol));
                                end
                            end
                            default: begin
                                // csi start or parameter bytes
                                finish = 1'b1;
                                n_vals = e_vals;
                                n_cnt  = e_cnt;
                                n_ps   = PS_CSI_PARAM;
                                if (r_ps == PS_CSI_START && c == CH_QUES) begin
                                    n_ps = PS_CSI_PARAM;
                                end else if (c == CH_SEMI &&
                                             e_cnt < PC_W'(MAX_PARAMS - 1)) begin
                                    n_cnt = e_cnt + 1'b1;
                                end else if (c >= CH_0 && c <= CH_9) begin
                                    n_vals[e_cnt] = (acc > 20'hffff) ? 16'hffff
                                                                     : acc[15:0];
                                end else begin
                                    n_ps = PS_TEXT;
                                    case (c)
                                        CH_UG, CH_BTICK: begin
                                            mv = 1'b1;
                                            tc = $signed(18'(d0));
                                        end
                                        CH_UA: begin
                                            mv = 1'b1;
                                            tr = $signed(18'(r_row)) - $signed(18'(nmov));
                                        end
                                        CH_UB, CH_LE: begin
                                            mv = 1'b1;
                                            tr = $signed(18'(r_row)) + $signed(18'(nmov));
                                        end
                                        CH_UC, CH_LA: begin
                                            mv = 1'b1;
                                            tc = $signed(18'(r_col)) + $signed(18'(nmov));
                                        end
                                        CH_UD: begin
                                            mv = 1'b1;
                                            tc = $signed(18'(r_col)) - $signed(18'(nmov));
                                        end
                                        CH_UE: begin
                                            mv = 1'b1;
                                            tc = '0;
                                            tr = $signed(18'(r_row)) + $signed(18'(nmov));
                                        end
                                        CH_UF: begin
                                            mv = 1'b1;
                                            tc = '0;
                                            tr = $signed(18'(r_row)) - $signed(18'(nmov));
                                        end
                                        CH_LD: begin
                                            mv = 1'b1;
                                            tr = $signed(18'(d0));
                                        end
                                        CH_UH, CH_LF_F: begin
                                            mv = 1'b1;
                                            tc = $signed(18'(d1));
                                            tr = $signed(18'(d0));
                                        end
                                        CH_UJ: begin
                                            n_pend = 1'b0;
                                            if (p0 == ERASE_TO_END) begin
                                                finish  = 1'b0;
                                                n_idx   = r_pos;
                                                n_end   = POS_W'(CELLS);
                                                n_state = SQ_FILL;
                                            end else if (p0 == ERASE_TO_START) begin
                                                finish  = 1'b0;
                                                n_idx   = '0;
                                                n_end   = r_pos;
                                                n_state = SQ_FILL;
                                            end else if (p0 == ERASE_ALL) begin
                                                finish  = 1'b0;
                                                n_idx   = '0;
                                                n_end   = POS_W'(CELLS);
                                                n_state = SQ_FILL;
                                            end
                                        end
                                        CH_UK: begin
                                            n_pend = 1'b0;
                                            if (p0 == ERASE_TO_END) begin
                                                if (r_col < COL_W'(SCREEN_COLS)) begin
                                                    finish  = 1'b0;
                                                    n_idx   = r_pos;
                                                    n_end   = r_pos - POS_W'(r_col)
                                                              + POS_W'(SCREEN_COLS);
                                                    n_state = SQ_FILL;
                                                end
                                            end else if (p0 == ERASE_TO_START) begin
                                                finish  = 1'b0;
                                                n_idx   = r_pos - POS_W'(r_col);
                                                n_end   = r_pos;
                                                n_state = SQ_FILL;
                                            end else if (p0 == ERASE_ALL) begin
                                                finish  = 1'b0;
                                                n_idx   = r_pos - POS_W'(r_col);
                                                n_end   = r_pos - POS_W'(r_col)
                                                          + POS_W'(SCREEN_COLS);
                                                n_state = SQ_FILL;
                                            end
                                        end
                                        CH_LM: begin
                                            finish  = 1'b0;
                                            n_sgr   = '0;
                                            n_state = SQ_SGR;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                            end
                        endcase
                        if (mv && tc >= 0 && tc < $signed(18'(SCREEN_COLS)) &&
                            tr >= 0 && tr < $signed(18'(SCREEN_ROWS))) begin
                            n_col = COL_W'($unsigned(tc));
                            n_row = ROW_W'($unsigned(tr));
                            n_pos = POS_W'(POS_W'(n_row) * POS_W'(SCREEN_COLS)
                                    + POS_W'(n_col));
                        end
                    end
                end
            end
            SQ_READ: begin
                finish  = 1'b1;
                n_ocell = r_rd_ok ? rdata : '0;
                n_state = SQ_IDLE;
            end
            SQ_SCR_RD: begin
                raddr   = AW'(r_idx + POS_W'(SCREEN_COLS));
                n_state = SQ_SCR_WR;
            end
            SQ_SCR_WR: begin
                we    = 1'b1;
                waddr = AW'(r_idx);
                wdata = rdata;
                if (r_idx == POS_W'(SCR_LAST)) begin
                    // bottom row is blanked by the fill pass
                    n_idx   = POS_W'(CELLS - SCREEN_COLS);
                    n_end   = POS_W'(CELLS);
                    n_state = SQ_FILL;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = SQ_SCR_RD;
                end
            end
            SQ_FILL: begin
                if (r_idx < r_end) begin
                    we    = 1'b1;
                    waddr = AW'(r_idx);
                    wdata = BLANK_CELL;
                    n_idx = r_idx + 1'b1;
                end else if (r_pend) begin
                    n_state = SQ_PUT;
                end else begin
                    finish  = 1'b1;
                    n_state = SQ_IDLE;
                end
            end
            SQ_PUT: begin
                we      = 1'b1;
                wdata   = {r_attr, r_pch};
                n_col   = r_col + 1'b1;
                n_pos   = r_pos + 1'b1;
                n_pend  = 1'b0;
                finish  = 1'b1;
                n_state = SQ_IDLE;
            end
            SQ_SGR: begin
                if (sp == 8'd0) begin
                    n_attr = ATTR_RESET;
                end else if (sp >= SGR_FG_LO && sp <= SGR_FG_HI) begin
                    sdiff  = sp - SGR_FG_LO;
                    n_attr = {r_attr[7:4], sdiff[3:0]};
                end else if (sp >= SGR_BG_LO && sp <= SGR_BG_HI) begin
                    sdiff  = sp - SGR_BG_LO;
                    n_attr = {r_attr[7:4], sdiff[3:0]};
                end else if (sp >= SGR_BR_LO && sp <= SGR_BR_HI) begin
                    sdiff  = sp - SGR_BR_LO;
                    n_attr = {r_attr[7:4], sdiff[3:0]};
                end else if (sfull == SGR_BOLD || sfull == SGR_ULINE) begin
                    n_attr = ATTR_BOLD;
                end else if (sfull == SGR_REV) begin
                    n_attr = ATTR_REV;
                end else if (sfull == SGR_NOREV) begin
                    n_attr = ATTR_RESET;
                end
                if (r_sgr == r_cnt) begin
                    finish  = 1'b1;
                    n_state = SQ_IDLE;
                end else begin
                    n_sgr = r_sgr + 1'b1;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_ps    <= PS_TEXT;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_vals[i] <= '0;
            end
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_scol  <= '0;
            r_srow  <= '0;
            r_attr  <= ATTR_RESET;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ps    <= n_ps;
            r_vals  <= n_vals;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pos   <= n_pos;
            r_scol  <= n_scol;
            r_srow  <= n_srow;
            r_attr  <= n_attr;
            r_pend  <= n_pend;
            if (finish) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_end   <= n_end;
        r_pch   <= n_pch;
        r_rd_ok <= n_rd_ok;
        r_sgr   <= n_sgr;
        if (finish) begin
            r_ocol  <= OCOL_W'(n_col);
            r_orow  <= OROW_W'(n_row);
            r_opos  <= OPOS_W'(n_pos);
            r_ocell <= n_ocell;
        end
    end

endmodule

`default_nettype wire

>>> design/ansi_text_console_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_console_engine
// byte-driven text console with escape and csi parsing over a cell screen
// ----------------------------------------------------------------------------
// Each input word either feeds one console byte or reads one screen cell, and
// every word returns exactly one result word with the cursor after it. A
// printable byte, control byte, cursor move or parameter digit is handled in
// the idle state unless it scrolls; a cell read adds a read state. The screen
// ram has one write and one read port, so a scroll copies each cell with a
// read state and a write state, then blanks the bottom row one cell a cycle;
// an erase blanks one cell a cycle (up to 2000) and an sgr sequence walks its
// parameters one a cycle. Words are queued two deep in front of the sequencer,
// so input can be taken while a result waits. The screen holds no reset
// value: cells never written read as anything.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_text_console_engine #(
    parameter int SCREEN_COLS = atce_pkg::DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = atce_pkg::DEF_SCREEN_ROWS,
    parameter int MAX_PARAMS  = atce_pkg::DEF_MAX_PARAMS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input words
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // char_code [7:0], read_addr [18:8], zero fill above
    input  wire logic [atce_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op [0]: 0 feed byte, 1 read cell
    input  wire logic                             s_axis_tuser,
    // result words
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // cursor_col [6:0], cursor_row [11:7], cursor_index [22:12],
    // cell_data [38:23], zero fill above
    output logic [atce_pkg::M_TDATA_W-1:0]        m_axis_tdata
);
    import atce_pkg::*;

    t_item              in_item, q_item;
    logic               q_valid, q_pop;
    logic [OCOL_W-1:0]  out_col;
    logic [OROW_W-1:0]  out_row;
    logic [OPOS_W-1:0]  out_pos;
    logic [CELL_W-1:0]  out_cell;

    assign in_item.op        = s_axis_tuser;
    assign in_item.char_code = s_axis_tdata[CHAR_W-1:0];
    assign in_item.read_addr = s_axis_tdata[CHAR_W +: RADDR_W];

    // front: takes words and queues them
    atce_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // back: parser, cursor and screen sequencer
    atce_back #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .MAX_PARAMS  (MAX_PARAMS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_col     (out_col),
        .o_row     (out_row),
        .o_pos     (out_pos),
        .o_cell    (out_cell)
    );

    assign m_axis_tdata = {1'b0, out_cell, out_pos, out_row, out_col};

`ifndef SYNTHESIS
    // the queue is never popped empty
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // reported index always matches the reported row and column
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(out_pos) == 32'(out_row) * SCREEN_COLS + 32'(out_col)))
        else $error("cursor index out of step with row and column");

    // reported row stays on the screen
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(out_row) < SCREEN_ROWS))
        else $error("cursor row off the screen");
`endif

endmodule

`default_nettype wire

>>> tb/atce_checker.sv
// ----------------------------------------------------------------------------
// atce_checker
// watches both word channels of the console engine, predicts each result
// word from its own model of the screen and parser, and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module atce_checker
    import atce_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    input  wire logic [S_TDATA_W-1:0]   i_s_tdata,
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [M_TDATA_W-1:0]   i_m_tdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = DEF_SCREEN_COLS;
    localparam int ROWS  = DEF_SCREEN_ROWS;
    localparam int NPAR  = DEF_MAX_PARAMS;
    localparam int CELLS = COLS * ROWS;

    // packed from the top down, so the column lands in the lowest bits
    typedef struct packed {
        logic [CELL_W-1:0] cdata;
        logic [OPOS_W-1:0] idx;
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
    } t_result;

    // model state
    logic [CELL_W-1:0] screen [CELLS];
    t_parse            pstate;
    int unsigned       params [NPAR];
    int unsigned       pcount;
    int                cur_col, cur_row, cur_pos, save_col, save_row;
    logic [7:0]        attr;
    t_result           cursor_q [$];

    function automatic void put_cell(int a, logic [CELL_W-1:0] v);
        if (a >= 0 && a < CELLS) screen[a] = v;
    endfunction

    function automatic void go_to(int c, int r);
        if (c < 0 || c >= COLS || r < 0 || r >= ROWS) return;
        cur_col = c;
        cur_row = r;
        cur_pos = r * COLS + c;
    endfunction

    function automatic void next_line();
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            cur_pos += COLS;
            return;
        end
        for (int i = 0; i < COLS * (ROWS - 1); i++) screen[i] = screen[i + COLS];
        for (int i = COLS * (ROWS - 1); i < CELLS; i++) screen[i] = BLANK_CELL;
    endfunction

    function automatic void blank_span(int first, int n);
        for (int i = first; i < first + n; i++) put_cell(i, BLANK_CELL);
    endfunction

    function automatic void apply_sgr();
        int unsigned full;
        int unsigned p;
        for (int unsigned i = 0; i <= pcount && i < NPAR; i++) begin
            full = params[i];
            p = full & 8'hff;
            if (p == 0) attr = ATTR_RESET;
            else if (p >= SGR_FG_LO && p <= SGR_FG_HI) attr = {attr[7:4], 4'(p - SGR_FG_LO)};
            else if (p >= SGR_BG_LO && p <= SGR_BG_HI) attr = {attr[7:4], 4'(p - SGR_BG_LO)};
            else if (p >= SGR_BR_LO && p <= SGR_BR_HI) attr = {attr[7:4], 4'(p - SGR_BR_LO)};
            else if (full == SGR_BOLD || full == SGR_ULINE) attr = ATTR_BOLD;
            else if (full == SGR_REV) attr = ATTR_REV;
            else if (full == SGR_NOREV) attr = ATTR_RESET;
        end
    endfunction

    function automatic void csi_finish(logic [7:0] c);
        int p0, n, d0, d1;
        p0 = params[0];
        n  = (p0 != 0) ? p0 : 1;
        d0 = (p0 != 0) ? p0 - 1 : 0;
        d1 = (params[1] != 0) ? int'(params[1]) - 1 : 0;
        pstate = PS_TEXT;
        case (c)
            CH_UG, CH_BTICK: go_to(d0, cur_row);
            CH_UA:           go_to(cur_col, cur_row - n);
            CH_UB, CH_LE:    go_to(cur_col, cur_row + n);
            CH_UC, CH_LA:    go_to(cur_col + n, cur_row);
            CH_UD:           go_to(cur_col - n, cur_row);
            CH_UE:           go_to(0, cur_row + n);
            CH_UF:           go_to(0, cur_row - n);
            CH_LD:           go_to(cur_col, d0);
            CH_UH, CH_LF_F:  go_to(d1, d0);
            CH_UJ: begin
                if (p0 == ERASE_TO_END) blank_span(cur_pos, CELLS - cur_pos);
                else if (p0 == ERASE_TO_START) blank_span(0, cur_pos);
                else if (p0 == ERASE_ALL) blank_span(0, CELLS);
            end
            CH_UK: begin
                if (p0 == ERASE_TO_END) begin
                    if (cur_col < COLS) blank_span(cur_pos, COLS - cur_col);
                end else if (p0 == ERASE_TO_START) begin
                    blank_span(cur_pos - cur_col, (cur_col < COLS) ? cur_col : COLS);
                end else if (p0 == ERASE_ALL) begin
                    blank_span(cur_pos - cur_col, COLS);
                end
            end
            CH_LM: apply_sgr();
            default: ;
        endcase
    endfunction

    function automatic void csi_byte(logic [7:0] c);
        int unsigned k, v;
        if (c == CH_SEMI && pcount < NPAR - 1) begin
            pcount++;
        end else if (c >= CH_0 && c <= CH_9) begin
            k = (pcount < NPAR) ? pcount : NPAR - 1;
            v = params[k] * 10 + (c - CH_0);
            params[k] = (v > 65535) ? 65535 : v;
        end else begin
            csi_finish(c);
        end
    endfunction

    function automatic void console_byte(logic [7:0] c);
        case (pstate)
            PS_TEXT: begin
                if (c >= CH_SPACE && c <= CH_TILDE) begin
                    if (cur_col >= COLS) begin
                        cur_col -= COLS;
                        cur_pos -= COLS;
                        next_line();
                    end
                    put_cell(cur_pos, {attr, c});
                    cur_pos++;
                    cur_col++;
                end else if (c == CH_ESC) begin
                    pstate = PS_ESC;
                end else if (c == CH_LF) begin
                    cur_pos -= cur_col;
                    cur_col = 0;
                    next_line();
                end else if (c == CH_CR) begin
                    cur_pos -= cur_col;
                    cur_col = 0;
                end else if (c == CH_DEL) begin
                    if (cur_col != 0) begin
                        cur_pos--;
                        cur_col--;
                        put_cell(cur_pos, BLANK_CELL);
                    end
                end else if (c == CH_BS) begin
                    if (cur_col != 0) begin
                        cur_col--;
                        cur_pos--;
                    end
                end
            end
            PS_ESC: begin
                pstate = PS_TEXT;
                if (c == CH_LBRK) pstate = PS_CSI_START;
                else if (c == CH_UE) go_to(0, cur_row + 1);
                else if (c == CH_UD) next_line();
                else if (c == CH_7) begin
                    save_col = cur_col;
                    save_row = cur_row;
                end else if (c == CH_8) begin
                    cur_col = save_col;
                    cur_row = save_row;
                    cur_pos = cur_row * COLS + cur_col;
                end
            end
            PS_CSI_START: begin
                foreach (params[i]) params[i] = 0;
                pcount = 0;
                pstate = PS_CSI_PARAM;
                // a leading question mark is swallowed
                if (c != CH_QUES) csi_byte(c);
            end
            default: csi_byte(c);
        endcase
    endfunction

    function automatic t_result predict_word(logic op, logic [7:0] c, logic [10:0] a);
        t_result r;
        r.cdata = '0;
        if (op == OP_FEED) console_byte(c);
        else if (a < CELLS) r.cdata = screen[a];
        r.col = OCOL_W'(cur_col);
        r.row = OROW_W'(cur_row);
        r.idx = OPOS_W'(cur_pos);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        if (!i_rst_n) begin
            pstate   = PS_TEXT;
            pcount   = 0;
            foreach (params[i]) params[i] = 0;
            cur_col  = 0;
            cur_row  = 0;
            cur_pos  = 0;
            save_col = 0;
            save_row = 0;
            attr     = ATTR_RESET;
            cursor_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                cursor_q.push_back(predict_word(i_s_tuser, i_s_tdata[7:0], i_s_tdata[18:8]));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[38:0];
                o_result_count++;
                if (cursor_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with nothing expected: %h", $realtime, got);
                end else begin
                    want = cursor_q.pop_front();
                    if (got !== want || i_m_tdata[M_TDATA_W-1:39] !== '0) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch col %0d/%0d row %0d/%0d idx %0d/%0d cell %h/%h (exp/got)",
                                     $realtime, want.col, got.col, want.row, got.row,
                                     want.idx, got.idx, want.cdata, got.cdata);
                    end
                end
            end
        end
        o_pending = cursor_q.size();
    end

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_pending      = 0;
        pstate         = PS_TEXT;
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the ansi text console engine
// ----------------------------------------------------------------------------
// The screen is first cleared by a full erase so that every cell read later
// holds a known value. A directed part then touches the printable extremes,
// the control bytes, cursor save and restore, saturating and off-screen
// moves, the attribute codes and reads at both ends of the range and beyond
// it. The random part mostly sends well-formed text, control and escape
// sequences with random content, mixed with reads and some noise bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import atce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS     = DEF_SCREEN_COLS * DEF_SCREEN_ROWS;
    // a scroll walks every cell of the screen and a result may then wait out a
    // long receiver stall, so this is many times the slowest word
    localparam int WDOG_LIMIT = 40000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // char_code [7:0], read_addr [18:8]
    logic                 s_tuser;     // op [0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // col [6:0], row [11:7], index [22:12], cell [38:23]

    int fail_count, pending, result_count;
    int tx_idle_pct, rx_idle_pct;
    int bytes_sent, reads_sent, idle_cnt;

    ansi_text_console_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    atce_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // one word on the input channel, the sender idling cycle by cycle first
    task automatic send_word(logic op, logic [7:0] c, logic [10:0] a);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, a, c};
        do @(posedge i_clk); while (!s_tready);
        if (op == OP_FEED) bytes_sent++;
        else reads_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        send_word(OP_FEED, c, 11'($urandom));
    endtask

    task automatic send_read(logic [10:0] a);
        send_word(OP_READ, 8'($urandom), a);
    endtask

    // esc [ then the parameter text then the final byte
    task automatic send_csi(string ptext, logic [7:0] fin);
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        for (int i = 0; i < ptext.len(); i++) send_byte(ptext[i]);
        send_byte(fin);
    endtask

    function automatic string rand_num();
        case ($urandom_range(9))
            0:       return "";
            1:       return "99999";
            2:       return $sformatf("%0d", $urandom_range(100, 300));
            default: return $sformatf("%0d", $urandom_range(0, 30));
        endcase
    endfunction

    function automatic string sgr_code();
        int pick [] = '{0, 1, 4, 7, 27, 30, 37, 40, 47, 90, 97, 287, 5, 65535};
        if ($urandom_range(3) == 0) return $sformatf("%0d", $urandom_range(0, 300));
        return $sformatf("%0d", pick[$urandom_range(pick.size() - 1)]);
    endfunction

    task automatic random_sequence();
        logic [7:0] finals [] = '{CH_UG, CH_BTICK, CH_UA, CH_UB, CH_LE, CH_UC, CH_LA,
                                  CH_UD, CH_UE, CH_UF, CH_LD, CH_UH, CH_LF_F, CH_UJ,
                                  CH_UK, CH_LM};
        logic [7:0] escs [] = '{CH_UD, CH_UE, CH_7, CH_8, CH_LBRK, 8'h4d, 8'h5a};
        string      ptext;
        int         n;
        case ($urandom_range(19))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
            end
            4: send_byte(($urandom_range(3) == 0) ? CH_LF : CH_CR);
            5: send_byte(($urandom_range(1) == 0) ? CH_BS : CH_DEL);
            6: begin
                send_byte(CH_ESC);
                send_byte(escs[$urandom_range(escs.size() - 1)]);
            end
            7, 8, 9, 10: begin
                ptext = ($urandom_range(7) == 0) ? "?" : "";
                ptext = {ptext, rand_num()};
                if ($urandom_range(1) == 0) ptext = {ptext, ";", rand_num()};
                send_csi(ptext, finals[$urandom_range(finals.size() - 1)]);
            end
            11: send_csi($sformatf("%0d", $urandom_range(0, 3)),
                         ($urandom_range(1) == 0) ? CH_UJ : CH_UK);
            12, 13: begin
                ptext = sgr_code();
                n = $urandom_range(0, 17);
                repeat (n) ptext = {ptext, ";", sgr_code()};
                send_csi(ptext, CH_LM);
            end
            14, 15, 16: send_read(11'($urandom_range(0, CELLS - 1)));
            17: send_read(11'($urandom_range(CELLS, 2047)));
            18: send_byte(8'($urandom_range(128, 255)));
            default: send_byte(8'($urandom));
        endcase
    endtask

    initial begin
        int total;
        tx_idle_pct = 13;
        rx_idle_pct = 86;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_FEED;
        s_tdata  = '0;
        m_tready = 1'b0;
        idle_cnt = 0;
        bytes_sent = 0;
        reads_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: clear first so every cell holds a known value
        send_csi("2", CH_UJ);
        send_byte(CH_SPACE);
        send_byte(CH_TILDE);
        send_byte(8'hff);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_read(11'd0);
        send_byte(CH_ESC);
        send_byte(CH_7);
        send_csi("25;80", CH_UH);          // bottom right corner
        send_byte(8'h41);
        send_byte(8'h42);                  // wraps and scrolls
        send_csi("99999;0", CH_LF_F);      // saturated, off screen, ignored
        send_csi("7;27;4;31;44;97;0", CH_LM);
        send_csi("?3", CH_UA);
        send_byte(CH_ESC);
        send_byte(CH_8);
        send_read(11'd1999);
        send_read(11'd2047);
        send_csi(";;;;;;;;;;;;;;;;", CH_LM); // too many parameters
        send_byte(CH_LF);
        send_byte(CH_CR);

        // random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 86;
                rx_idle_pct = 13;
            end else if (ph == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            total = bytes_sent + reads_sent;
            while (bytes_sent + reads_sent < total + 75) random_sequence();
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);

        $display("fed %0d console bytes and %0d cell reads, checked %0d result words",
                 bytes_sent, reads_sent, result_count);
        $display("covered text, wrap, scroll, controls, escapes, csi moves, erases and sgr");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
